FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Standalone header; bodies compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication check
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication check
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

FILE: hw/rtl/wvp_pkg.sv
// Types and constants of the windowed velocity predictor.
// No dependencies.
package wvp_pkg;

    localparam int CX_W    = 18;   // Q.1 center
    localparam int FRAME_W = 16;
    localparam int VEL_W   = 32;   // Q.8 velocity
    localparam int DC_W    = 19;   // center step
    localparam int DT_W    = 18;   // signed frame distance
    localparam int DVS_W   = 16;   // divisor magnitude
    localparam int PROD_W  = VEL_W + DT_W;
    localparam int VEL_SHIFT = 7;

    localparam logic signed [VEL_W-1:0] VEL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN = 32'sh8000_0000;

    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_PREDICT = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic [14:0]        box_w;
        logic [14:0]        box_h;
        logic [15:0]        det_frame;
        logic               is_tracked;
        logic [15:0]        query_frame;
    } wvp_in_t;

    typedef struct packed {
        logic signed [31:0] pred_cx;
        logic signed [31:0] pred_cy;
        logic               pred_valid;
        logic               pred_fault;
    } wvp_out_t;

    // classified command from front to back
    typedef struct packed {
        logic                    is_pred;
        logic                    tracked;
        logic signed [CX_W-1:0]  cx;
        logic signed [CX_W-1:0]  cy;
        logic [FRAME_W-1:0]      frame;
        logic [FRAME_W-1:0]      query;
    } wvp_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VEL_DIV,
        ST_VEL_WR,
        ST_MEAN_DIV,
        ST_MUL,
        ST_PROJ
    } wvp_state_t;

endpackage

FILE: hw/rtl/wvp_chan_if.sv
// Valid/ready channel interface carrying one payload per transfer.
// Payload type is supplied by the instantiating level.
interface wvp_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/wvp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wvp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 9,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: hw/rtl/wvp_div.sv
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
// Depends on nothing; magnitudes only, signs handled by the caller.
module wvp_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num_a,
    input  logic [NUM_W-1:0] num_b,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo_a,
    output logic [NUM_W-1:0] quo_b
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] na_reg, nb_reg;
    logic [DEN_W-1:0] ra_reg, rb_reg, den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   ra_sh, rb_sh, ra_sub, rb_sub;
    logic             ra_ge, rb_ge;

    // one restoring step per lane
    always_comb
    begin
        ra_sh  = {ra_reg, na_reg[NUM_W-1]};
        rb_sh  = {rb_reg, nb_reg[NUM_W-1]};
        ra_ge  = ra_sh >= {1'b0, den_reg};
        rb_ge  = rb_sh >= {1'b0, den_reg};
        ra_sub = ra_sh - {1'b0, den_reg};
        rb_sub = rb_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out, quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            na_reg  <= num_a;
            nb_reg  <= num_b;
            ra_reg  <= '0;
            rb_reg  <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            na_reg <= {na_reg[NUM_W-2:0], ra_ge};
            nb_reg <= {nb_reg[NUM_W-2:0], rb_ge};
            ra_reg <= ra_ge ? ra_sub[DEN_W-1:0] : ra_sh[DEN_W-1:0];
            rb_reg <= rb_ge ? rb_sub[DEN_W-1:0] : rb_sh[DEN_W-1:0];
        end
    end

    assign done  = done_reg;
    assign quo_a = na_reg;
    assign quo_b = nb_reg;
endmodule

FILE: hw/rtl/wvp_front.sv
// Front end: takes input transfers, computes Q.1 centers, queues commands.
// Depends on wvp_pkg, wvp_chan_if and assert_macros.svh.
`include "assert_macros.svh"
module wvp_front
    import wvp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    wvp_chan_if.sink   req,
    output logic       cmd_valid,
    output wvp_cmd_t   cmd,
    input  logic       cmd_pop
);
    logic [1:0] count_reg;
    logic       wr_ptr_reg, rd_ptr_reg;
    wvp_cmd_t   q_reg [2];
    wvp_cmd_t   cls;
    logic       push;

    // classify and compute center = 2*edge + size
    always_comb
    begin
        cls.is_pred = (req.data.op == OP_PREDICT);
        cls.tracked = req.data.is_tracked;
        cls.cx      = CX_W'($signed({req.data.box_x, 1'b0})) + CX_W'(req.data.box_w);
        cls.cy      = CX_W'($signed({req.data.box_y, 1'b0})) + CX_W'(req.data.box_h);
        cls.frame   = req.data.det_frame;
        cls.query   = req.data.query_frame;
    end

    assign req.ready = (count_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // two-entry command queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, cmd_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    `ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, count_reg <= 2'd2)
    `ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, cmd_pop, count_reg != 2'd0)
    `ASSERT_NEXT(a_fill_grows, clk, rst_n, push && !cmd_pop, count_reg == $past(count_reg) + 2'd1)
endmodule

FILE: hw/rtl/wvp_back.sv
// Back end: window update with serial velocity divide, and prediction.
// Depends on wvp_pkg, wvp_chan_if, wvp_div, wvp_ram and assert_macros.svh.
`include "assert_macros.svh"
module wvp_back
    import wvp_pkg::*;
#(
    parameter int WINDOW_POINTS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  wvp_cmd_t   cmd,
    output logic       cmd_pop,
    wvp_chan_if.source rsp
);
    localparam int PAIR_DEPTH = WINDOW_POINTS - 1;
    localparam int PTR_W = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int TP_W  = $clog2(WINDOW_POINTS + 1);
    localparam int SUM_W = VEL_W + $clog2(PAIR_DEPTH + 1);
    localparam int DIV_W = SUM_W;
    localparam logic [TP_W-1:0]  TP_FULL  = TP_W'(WINDOW_POINTS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(PAIR_DEPTH - 1);

    wvp_state_t state_reg, state_next;

    logic signed [SUM_W-1:0]  vel_sum_x_reg, vel_sum_y_reg;
    logic [PTR_W-1:0]         ring_ptr_reg;
    logic [TP_W-1:0]          tp_reg;
    logic signed [CX_W-1:0]   last_trk_cx_reg, last_trk_cy_reg;
    logic [FRAME_W-1:0]       last_trk_frame_reg;
    logic signed [CX_W-1:0]   last_any_cx_reg, last_any_cy_reg;
    logic                     any_seen_reg, fault_reg;
    logic signed [DC_W-1:0]   dc_x_reg, dc_y_reg;
    logic                     gap_zero_reg, qneg_x_reg, qneg_y_reg, pairs_zero_reg;
    logic signed [DT_W-1:0]   dt_reg;
    logic signed [VEL_W-1:0]  mean_x_reg, mean_y_reg;
    logic signed [PROD_W-1:0] disp_x_reg, disp_y_reg;
    wvp_out_t                 out_reg;
    logic                     out_valid_reg;

    // control strobes
    logic out_free, simple_push, vel_setup, vel_commit, mean_setup;
    logic emit_empty, emit_proj, div_start, ram_re, ram_we;

    // front-of-item arithmetic
    logic signed [DC_W-1:0]    dcx, dcy;
    logic [DC_W-1:0]           dcx_mag, dcy_mag;
    logic signed [FRAME_W:0]   gap;
    logic [DVS_W-1:0]          gap_mag;
    logic signed [DT_W-1:0]    dt;
    logic [SUM_W-1:0]          sum_mag_x, sum_mag_y;
    logic [DIV_W-1:0]          num_a, num_b;
    logic [DVS_W-1:0]          den;
    logic                      div_done;
    logic [DIV_W-1:0]          quo_a, quo_b;
    logic signed [DIV_W:0]     qs_a, qs_b;
    logic signed [VEL_W-1:0]   vx, vy, old_x, old_y;
    logic [2*VEL_W-1:0]        ram_rdata;
    logic [VEL_W:0]            proj_x, proj_y;

    function automatic logic signed [VEL_W-1:0] zero_gap_vel(input logic signed [DC_W-1:0] d);
        logic signed [VEL_W-1:0] v;
        if (d > 0)
        begin
            v = VEL_MAX;
        end
        else if (d < 0)
        begin
            v = VEL_MIN;
        end
        else
        begin
            v = '0;
        end
        return v;
    endfunction

    // c + trunc0(disp / 128), saturated; msb of result is the saturation flag
    function automatic logic [VEL_W:0] project(input logic signed [CX_W-1:0] c,
                                               input logic signed [PROD_W-1:0] disp);
        logic [PROD_W-1:0]        mag;
        logic signed [PROD_W-1:0] q;
        logic signed [PROD_W+1:0] r;
        logic [VEL_W:0]           res;
        mag = disp[PROD_W-1] ? PROD_W'(-disp) : PROD_W'(disp);
        q   = disp[PROD_W-1] ? -$signed(mag >> VEL_SHIFT) : $signed(mag >> VEL_SHIFT);
        r   = (PROD_W+2)'(c) + (PROD_W+2)'(q);
        if (r > (PROD_W+2)'(VEL_MAX))
        begin
            res = {1'b1, VEL_MAX};
        end
        else if (r < (PROD_W+2)'(VEL_MIN))
        begin
            res = {1'b1, VEL_MIN};
        end
        else
        begin
            res = {1'b0, r[VEL_W-1:0]};
        end
        return res;
    endfunction

    // operands of the item at the queue head
    always_comb
    begin
        dcx       = DC_W'(cmd.cx) - DC_W'(last_trk_cx_reg);
        dcy       = DC_W'(cmd.cy) - DC_W'(last_trk_cy_reg);
        dcx_mag   = dcx[DC_W-1] ? DC_W'(-dcx) : DC_W'(dcx);
        dcy_mag   = dcy[DC_W-1] ? DC_W'(-dcy) : DC_W'(dcy);
        gap       = $signed({1'b0, cmd.frame}) - $signed({1'b0, last_trk_frame_reg});
        gap_mag   = gap[FRAME_W] ? DVS_W'(-gap) : gap[DVS_W-1:0];
        dt        = $signed({2'b0, cmd.query}) + DT_W'(1)
                    - $signed({2'b0, last_trk_frame_reg});
        sum_mag_x = vel_sum_x_reg[SUM_W-1] ? SUM_W'(-vel_sum_x_reg) : SUM_W'(vel_sum_x_reg);
        sum_mag_y = vel_sum_y_reg[SUM_W-1] ? SUM_W'(-vel_sum_y_reg) : SUM_W'(vel_sum_y_reg);
        if (mean_setup)
        begin
            num_a = sum_mag_x;
            num_b = sum_mag_y;
            den   = DVS_W'(tp_reg - 1'b1);
        end
        else
        begin
            num_a = DIV_W'({dcx_mag, {VEL_SHIFT{1'b0}}});
            num_b = DIV_W'({dcy_mag, {VEL_SHIFT{1'b0}}});
            den   = gap_mag;
        end
    end

    // signed quotients and the velocities they give
    always_comb
    begin
        qs_a  = qneg_x_reg ? -$signed({1'b0, quo_a}) : $signed({1'b0, quo_a});
        qs_b  = qneg_y_reg ? -$signed({1'b0, quo_b}) : $signed({1'b0, quo_b});
        vx    = gap_zero_reg ? zero_gap_vel(dc_x_reg) : qs_a[VEL_W-1:0];
        vy    = gap_zero_reg ? zero_gap_vel(dc_y_reg) : qs_b[VEL_W-1:0];
        old_x = ram_rdata[2*VEL_W-1:VEL_W];
        old_y = ram_rdata[VEL_W-1:0];
        proj_x = project(last_trk_cx_reg, disp_x_reg);
        proj_y = project(last_trk_cy_reg, disp_y_reg);
    end

    assign out_free = !out_valid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && tp_reg != '0)
                begin
                    if (cmd.is_pred)
                    begin
                        state_next = ST_MEAN_DIV;
                    end
                    else if (cmd.tracked)
                    begin
                        state_next = ST_VEL_DIV;
                    end
                end
            end
            ST_VEL_DIV:  if (div_done) state_next = ST_VEL_WR;
            ST_VEL_WR:   state_next = ST_IDLE;
            ST_MEAN_DIV: if (div_done) state_next = ST_MUL;
            ST_MUL:      state_next = ST_PROJ;
            ST_PROJ:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        simple_push = 1'b0;
        vel_setup   = 1'b0;
        vel_commit  = 1'b0;
        mean_setup  = 1'b0;
        emit_empty  = 1'b0;
        emit_proj   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (!cmd.is_pred)
                    begin
                        if (cmd.tracked && tp_reg != '0)
                        begin
                            vel_setup = 1'b1;
                        end
                        else
                        begin
                            simple_push = 1'b1;
                        end
                    end
                    else if (tp_reg != '0)
                    begin
                        mean_setup = 1'b1;
                    end
                    else if (out_free)
                    begin
                        emit_empty = 1'b1;
                    end
                end
            end
            ST_VEL_WR: vel_commit = 1'b1;
            ST_PROJ:   emit_proj  = out_free;
            default:   ;
        endcase
        div_start = vel_setup || mean_setup;
        ram_re    = vel_setup;
        ram_we    = vel_commit;
        cmd_pop   = simple_push || vel_commit || emit_empty || emit_proj;
    end

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            vel_sum_x_reg      <= '0;
            vel_sum_y_reg      <= '0;
            ring_ptr_reg       <= '0;
            tp_reg             <= '0;
            last_trk_cx_reg    <= '0;
            last_trk_cy_reg    <= '0;
            last_trk_frame_reg <= '0;
            last_any_cx_reg    <= '0;
            last_any_cy_reg    <= '0;
            any_seen_reg       <= 1'b0;
            fault_reg          <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (simple_push || vel_commit)
            begin
                last_any_cx_reg <= cmd.cx;
                last_any_cy_reg <= cmd.cy;
                any_seen_reg    <= 1'b1;
                if (cmd.tracked)
                begin
                    last_trk_cx_reg    <= cmd.cx;
                    last_trk_cy_reg    <= cmd.cy;
                    last_trk_frame_reg <= cmd.frame;
                    if (tp_reg < TP_FULL)
                    begin
                        tp_reg <= tp_reg + 1'b1;
                    end
                end
            end
            // retire oldest pair once the window is full
            if (vel_commit)
            begin
                vel_sum_x_reg <= vel_sum_x_reg + SUM_W'(vx)
                                 - ((tp_reg == TP_FULL) ? SUM_W'(old_x) : '0);
                vel_sum_y_reg <= vel_sum_y_reg + SUM_W'(vy)
                                 - ((tp_reg == TP_FULL) ? SUM_W'(old_y) : '0);
                ring_ptr_reg  <= (ring_ptr_reg == PTR_LAST) ? '0 : ring_ptr_reg + 1'b1;
                if (gap_zero_reg)
                begin
                    fault_reg <= 1'b1;
                end
            end
            if (emit_empty || emit_proj)
            begin
                fault_reg     <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (vel_setup)
        begin
            dc_x_reg     <= dcx;
            dc_y_reg     <= dcy;
            gap_zero_reg <= (gap == '0);
            qneg_x_reg   <= dcx[DC_W-1] ^ gap[FRAME_W];
            qneg_y_reg   <= dcy[DC_W-1] ^ gap[FRAME_W];
        end
        if (mean_setup)
        begin
            dt_reg         <= dt;
            qneg_x_reg     <= vel_sum_x_reg[SUM_W-1];
            qneg_y_reg     <= vel_sum_y_reg[SUM_W-1];
            pairs_zero_reg <= (tp_reg == TP_W'(1));
        end
        if (state_reg == ST_MEAN_DIV && div_done)
        begin
            mean_x_reg <= pairs_zero_reg ? '0 : qs_a[VEL_W-1:0];
            mean_y_reg <= pairs_zero_reg ? '0 : qs_b[VEL_W-1:0];
        end
        if (state_reg == ST_MUL)
        begin
            disp_x_reg <= mean_x_reg * dt_reg;
            disp_y_reg <= mean_y_reg * dt_reg;
        end
        if (emit_empty)
        begin
            out_reg.pred_cx    <= any_seen_reg ? VEL_W'(last_any_cx_reg) : '0;
            out_reg.pred_cy    <= any_seen_reg ? VEL_W'(last_any_cy_reg) : '0;
            out_reg.pred_valid <= any_seen_reg;
            out_reg.pred_fault <= fault_reg;
        end
        else if (emit_proj)
        begin
            out_reg.pred_cx    <= proj_x[VEL_W-1:0];
            out_reg.pred_cy    <= proj_y[VEL_W-1:0];
            out_reg.pred_valid <= 1'b1;
            out_reg.pred_fault <= fault_reg || proj_x[VEL_W] || proj_y[VEL_W];
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    wvp_div #(.NUM_W(DIV_W), .DEN_W(DVS_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num_a (num_a),
        .num_b (num_b),
        .den   (den),
        .done  (div_done),
        .quo_a (quo_a),
        .quo_b (quo_b)
    );

    // pair velocity ring, x in the upper half
    wvp_ram #(.WIDTH(2*VEL_W), .DEPTH(PAIR_DEPTH), .AW(PTR_W)) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ring_ptr_reg),
        .wdata ({vx, vy}),
        .re    (ram_re),
        .raddr (ring_ptr_reg),
        .rdata (ram_rdata)
    );

    `ASSERT_IMPLY(a_tp_range, clk, rst_n, 1'b1, tp_reg <= TP_FULL)
    `ASSERT_IMPLY(a_ptr_range, clk, rst_n, 1'b1, ring_ptr_reg <= PTR_LAST)
    `ASSERT_IMPLY(a_pop_has_cmd, clk, rst_n, cmd_pop, cmd_valid)
    `ASSERT_IMPLY(a_div_done_state, clk, rst_n, div_done, state_reg == ST_VEL_DIV || state_reg == ST_MEAN_DIV)
endmodule

FILE: hw/rtl/windowed_velocity_predictor_unit.sv
// Top level of the windowed constant-velocity center predictor.
// Depends on wvp_pkg, wvp_chan_if, wvp_front and wvp_back.
//
//  channel | dir | payload   | transfer
//  req     | in  | wvp_in_t  | one detection push or prediction request
//  rsp     | out | wvp_out_t | one prediction result per request
//
// Untracked push, first tracked push: retired straight from idle. Tracked push:
// bit-serial velocity divide, then the window write (ST_VEL_DIV, ST_VEL_WR).
// Prediction: the same divider for the mean, then multiply and project.
// Reset clears all control state at once; no clearing pass is needed.
// A two-entry queue takes new requests while the back end works or the
// result register waits on rsp.ready.
module windowed_velocity_predictor_unit
    import wvp_pkg::*;
#(
    parameter int WINDOW_POINTS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    wvp_chan_if.sink   req,
    wvp_chan_if.source rsp
);
    logic     cmd_valid;
    logic     cmd_pop;
    wvp_cmd_t cmd;

    wvp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    wvp_back #(.WINDOW_POINTS(WINDOW_POINTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );
endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench of windowed_velocity_predictor_unit: directed and random pushes and predictions.
// Depends on wvp_pkg, wvp_chan_if and the RTL of the predictor.
module tb;
    import wvp_pkg::*;

    localparam int WIN = 10;
    localparam int PAIRS = WIN - 1;
    localparam longint CYCLE_LIMIT = 1500000;

    logic clk;
    logic rst_n;
    int   errors;
    longint cycles;
    int   src_idle_pct;
    int   snk_idle_pct;

    wvp_chan_if #(.T(wvp_in_t))  req ();
    wvp_chan_if #(.T(wvp_out_t)) rsp ();

    windowed_velocity_predictor_unit #(.WINDOW_POINTS(WIN)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // predictor state
    longint vel_ring_x [PAIRS];
    longint vel_ring_y [PAIRS];
    longint vsum_x, vsum_y;
    int     slot;
    int     n_points;
    longint trk_cx, trk_cy, trk_frame;
    longint any_cx, any_cy;
    bit     seen_box;
    bit     gap_fault;
    wvp_out_t expected_preds [$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // cycle limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic longint step_velocity(longint dc, longint gap);
        if (gap == 0)
        begin
            gap_fault = 1'b1;
            if (dc > 0)
                return 64'sd2147483647;
            if (dc < 0)
                return -64'sd2147483648;
            return 0;
        end
        return (dc * 128) / gap;
    endfunction

    function automatic longint extrapolate(longint c, longint sum, longint np, longint dt,
                                           inout bit sat);
        longint mean;
        longint disp;
        longint q;
        longint r;
        mean = (np > 0) ? sum / np : 0;
        disp = mean * dt;
        q = (disp < 0) ? -((-disp) >>> 7) : (disp >>> 7);
        r = c + q;
        if (r > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (r < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return r;
    endfunction

    // update predictor with one accepted item
    task automatic predict_item(input wvp_in_t it);
        longint cx, cy, fr, vx, vy, dt;
        bit sat;
        wvp_out_t o;
        if (it.op == OP_PUSH)
        begin
            cx = 2 * longint'(it.box_x) + longint'(it.box_w);
            cy = 2 * longint'(it.box_y) + longint'(it.box_h);
            fr = longint'(it.det_frame);
            any_cx = cx;
            any_cy = cy;
            seen_box = 1'b1;
            if (it.is_tracked)
            begin
                if (n_points > 0)
                begin
                    vx = step_velocity(cx - trk_cx, fr - trk_frame);
                    vy = step_velocity(cy - trk_cy, fr - trk_frame);
                    if (n_points >= WIN)
                    begin
                        vsum_x -= vel_ring_x[slot];
                        vsum_y -= vel_ring_y[slot];
                    end
                    vel_ring_x[slot] = vx;
                    vel_ring_y[slot] = vy;
                    vsum_x += vx;
                    vsum_y += vy;
                    slot = (slot + 1) % PAIRS;
                end
                if (n_points < WIN)
                    n_points++;
                trk_cx = cx;
                trk_cy = cy;
                trk_frame = fr;
            end
        end
        else
        begin
            sat = 1'b0;
            o = '0;
            if (n_points > 0)
            begin
                dt = longint'(it.query_frame) + 1 - trk_frame;
                o.pred_cx = 32'(extrapolate(trk_cx, vsum_x, longint'(n_points - 1), dt, sat));
                o.pred_cy = 32'(extrapolate(trk_cy, vsum_y, longint'(n_points - 1), dt, sat));
                o.pred_valid = 1'b1;
            end
            else if (seen_box)
            begin
                o.pred_cx = 32'(any_cx);
                o.pred_cy = 32'(any_cy);
                o.pred_valid = 1'b1;
            end
            o.pred_fault = gap_fault | sat;
            gap_fault = 1'b0;
            expected_preds.push_back(o);
        end
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        wvp_out_t exp_o;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_preds.size() == 0)
            begin
                $display("%0t unexpected transfer: actual %p", $time, rsp.data);
                errors++;
            end
            else
            begin
                exp_o = expected_preds.pop_front();
                if (rsp.data.pred_cx !== exp_o.pred_cx)
                begin
                    $display("%0t pred_cx expected %0d actual %0d", $time,
                             exp_o.pred_cx, rsp.data.pred_cx);
                    errors++;
                end
                if (rsp.data.pred_cy !== exp_o.pred_cy)
                begin
                    $display("%0t pred_cy expected %0d actual %0d", $time,
                             exp_o.pred_cy, rsp.data.pred_cy);
                    errors++;
                end
                if (rsp.data.pred_valid !== exp_o.pred_valid)
                begin
                    $display("%0t pred_valid expected %0b actual %0b", $time,
                             exp_o.pred_valid, rsp.data.pred_valid);
                    errors++;
                end
                if (rsp.data.pred_fault !== exp_o.pred_fault)
                begin
                    $display("%0t pred_fault expected %0b actual %0b", $time,
                             exp_o.pred_fault, rsp.data.pred_fault);
                    errors++;
                end
            end
        end
        rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // send one item, waiting for its transfer; valid stays up for a following item
    task automatic send_item(input wvp_in_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= it;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_item(it);
    endtask

    function automatic wvp_in_t make_push(int x, int y, int w, int h, int fr, bit trk);
        wvp_in_t it;
        it = '0;
        it.op = OP_PUSH;
        it.box_x = 16'(x);
        it.box_y = 16'(y);
        it.box_w = 15'(w);
        it.box_h = 15'(h);
        it.det_frame = 16'(fr);
        it.is_tracked = trk;
        it.query_frame = 16'($urandom);
        return it;
    endfunction

    function automatic wvp_in_t make_query(int q);
        wvp_in_t it;
        it = wvp_in_t'({$urandom, $urandom, $urandom});
        it.op = OP_PREDICT;
        it.query_frame = 16'(q);
        return it;
    endfunction

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (expected_preds.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // directed: empty, untracked, single point, extremes, zero gap, backward frames
    task automatic test_directed();
        send_item(make_query(16'hFFFF));
        send_item(make_push(-32768, 32767, 32767, 0, 5, 0));
        send_item(make_query(0));
        send_item(make_push(100, -200, 40, 30, 10, 1));
        send_item(make_query(10));
        send_item(make_push(300, -400, 40, 30, 10, 1));
        send_item(make_query(12));
        send_item(make_push(300, -400, 40, 30, 10, 1));
        send_item(make_push(200, -100, 40, 30, 10, 1));
        send_item(make_query(11));
        send_item(make_push(32767, -32768, 32767, 0, 65535, 1));
        send_item(make_push(-32768, 32767, 0, 32767, 0, 1));
        send_item(make_query(65535));
        send_item(make_push(-32768, 32767, 0, 32767, 65535, 1));
        send_item(make_push(32767, -32768, 32767, 0, 1, 1));
        send_item(make_query(0));
        send_item(make_query(65535));
        send_item(make_push(0, 0, 0, 0, 1, 1));
        send_item(make_query(40000));
    endtask

    // random tracks: mostly coherent frame sequences, some noise
    task automatic test_random(input int n_items);
        int fr;
        int x, y;
        wvp_in_t it;
        fr = $urandom_range(65535);
        x = $urandom_range(2000) - 1000;
        y = $urandom_range(2000) - 1000;
        for (int i = 0; i < n_items; i++)
        begin
            case ($urandom_range(9))
                0, 1, 2:
                    send_item(make_query($urandom_range(3) == 0 ? $urandom
                                         : fr + $urandom_range(5)));
                3:
                    send_item(make_push($urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom));
                default:
                begin
                    fr = fr + ($urandom_range(15) == 0 ? -$urandom_range(3)
                               : $urandom_range(3));
                    x = x + $urandom_range(64) - 32;
                    y = y + $urandom_range(64) - 32;
                    it = make_push(x, y, $urandom_range(32767), $urandom_range(32767),
                                   fr & 16'hFFFF, $urandom_range(7) != 0);
                    send_item(it);
                end
            endcase
        end
    endtask

    initial
    begin
        errors = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        rsp.ready = 1'b0;
        src_idle_pct = 7;
        snk_idle_pct = 46;
        vsum_x = 0;
        vsum_y = 0;
        slot = 0;
        n_points = 0;
        trk_cx = 0;
        trk_cy = 0;
        trk_frame = 0;
        any_cx = 0;
        any_cy = 0;
        seen_box = 0;
        gap_fault = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(480);
        // pause until all results are back
        wait_drained();
        src_idle_pct = 46;
        snk_idle_pct = 7;
        test_random(500);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random(500);
        wait_drained();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
